// ----- hdl/srss_pkg.sv -----
package srss_pkg;

   localparam int ROW_W       = 8;
   localparam int COL_W       = 16;
   localparam int ROW_COUNT_W = 9;
   localparam int COL_COUNT_W = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int FILL_OUT_W  = 6;
   localparam int TOTAL_OUT_W = 14;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 9'd256;
   localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 17'd65536;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic KIND_INSERT = 1'b0;

   typedef struct packed {
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
      logic             rerr;
   } item_type;

   typedef struct packed {
      logic                   found;
      logic [FILL_OUT_W-1:0]  row_fill;
      logic [TOTAL_OUT_W-1:0] total_entries;
      logic                   overflow;
      logic                   range_error;
      logic                   done_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_TAIL,
      ST_RESP
   } back_state_type;

endpackage

// ----- hdl/srss_ram.sv -----
module srss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/srss_front.sv -----
module srss_front #(
   parameter int ROWS     = 256,
   parameter int COL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [srss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [srss_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_kind,
   input  logic [srss_pkg::ROW_W-1:0]           req_row,
   input  logic [srss_pkg::COL_W-1:0]           req_col,
   input  logic                                 req_batch_last,
   input  logic                                 q_full,
   output logic                                 push,
   output srss_pkg::item_type                   push_item
);
   import srss_pkg::*;

   localparam logic [32:0] COL_LIM = 33'(1) << COL_BITS;

   logic [ROW_COUNT_W-1:0] row_count_ff;
   logic [COL_COUNT_W-1:0] col_count_ff;
   logic [31:0]            row_wide;
   logic [32:0]            col_wide;
   logic                   row_bad;
   logic                   col_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         col_count_ff <= COL_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[ROW_COUNT_W-1:0];
            CSR_COL_COUNT: col_count_ff <= csr_wdata[COL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // The range check is settled here so that the back end only ever sees a
   // row and column that fit its memories.
   assign row_wide = 32'(req_row);
   assign col_wide = 33'(req_col);
   assign row_bad  = ({1'b0, req_row} >= row_count_ff) || (row_wide >= 32'(ROWS));
   assign col_bad  = ({1'b0, req_col} >= col_count_ff) || (col_wide >= COL_LIM);

   assign push = req_valid && !q_full;

   always_comb begin
      push_item.kind = req_kind;
      push_item.row  = req_row;
      push_item.col  = req_col;
      push_item.last = req_batch_last;
      push_item.rerr = row_bad || col_bad;
   end

endmodule

// ----- hdl/srss_queue.sv -----
module srss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  srss_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output srss_pkg::item_type head
);
   import srss_pkg::*;

   item_type    mem_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/srss_back.sv -----
module srss_back #(
   parameter int ROWS        = 256,
   parameter int MAX_PER_ROW = 32,
   parameter int COL_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  srss_pkg::item_type q_item,
   output logic               q_pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output srss_pkg::rsp_type  rsp
);
   import srss_pkg::*;

   localparam int RB     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FW     = $clog2(MAX_PER_ROW + 1);
   localparam int EDEPTH = ROWS * MAX_PER_ROW;
   localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
   localparam int TW     = $clog2(EDEPTH + 1);

   back_state_type      st_ff, st_in;
   item_type            item_ff, item_in;
   logic [FW-1:0]       n_ff, n_in;
   logic [FW-1:0]       chk_ff, chk_in;
   logic                shift_ff, shift_in;
   logic [COL_BITS-1:0] carry_ff, carry_in;
   logic                found_ff, found_in;
   logic                ovf_ff, ovf_in;
   logic                ins_ff, ins_in;
   logic [TW-1:0]       total_ff;
   logic [ROWS-1:0]     valid_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                fill_rd_en;
   logic                fill_wr_en;
   logic [RB-1:0]       fill_rd_addr;
   logic [FW-1:0]       fill_rdata;
   logic [FW-1:0]       fill_cur;
   logic                ent_rd_en;
   logic [FW-1:0]       ent_rd_slot;
   logic                ent_wr_en;
   logic [FW-1:0]       ent_wr_slot;
   logic [COL_BITS-1:0] ent_wr_data;
   logic [COL_BITS-1:0] ent_rdata;

   logic [RB-1:0]       row_idx;
   logic [COL_BITS-1:0] key;
   logic                is_ins;
   logic                full;
   logic                last_slot;
   logic                ge;
   logic                eq;
   logic                rsp_free;
   logic                load_rsp;
   logic [FW-1:0]       fill_new;
   logic [TW-1:0]       total_new;
   logic [31:0]         fill_wide;
   logic [31:0]         total_wide;

   function automatic logic [EAW-1:0] ent_addr(input logic [RB-1:0] r, input logic [FW-1:0] s);
      logic [31:0] a;
      a = 32'(r) * 32'(MAX_PER_ROW) + 32'(s);
      return a[EAW-1:0];
   endfunction

   srss_ram #(.WIDTH(FW), .DEPTH(ROWS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (row_idx),
      .wr_data (fill_new),
      .rd_en   (fill_rd_en),
      .rd_addr (fill_rd_addr),
      .rd_data (fill_rdata)
   );

   srss_ram #(.WIDTH(COL_BITS), .DEPTH(EDEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_addr(row_idx, ent_wr_slot)),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_addr(row_idx, ent_rd_slot)),
      .rd_data (ent_rdata)
   );

   assign row_idx      = RB'(item_ff.row);
   assign fill_rd_addr = RB'(q_item.row);
   assign key          = COL_BITS'(item_ff.col);
   assign is_ins       = (item_ff.kind == KIND_INSERT);
   assign full         = (n_ff == FW'(MAX_PER_ROW));
   assign last_slot    = (chk_ff == FW'(n_ff - FW'(1)));
   assign ge           = (ent_rdata >= key);
   assign eq           = (ent_rdata == key);
   // A row whose fill was never written since reset holds nothing.
   assign fill_cur     = valid_ff[row_idx] ? fill_rdata : '0;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign fill_new     = FW'(n_ff + FW'(ins_ff));
   assign total_new    = TW'(total_ff + TW'(ins_ff));
   assign fill_wide    = item_ff.rerr ? 32'd0 : 32'(fill_new);
   assign total_wide   = 32'(total_new);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               st_in = q_item.rerr ? ST_RESP : ST_FILL;
            end
         end
         ST_FILL: st_in = (fill_cur == '0) ? ST_RESP : ST_SCAN;
         ST_SCAN: begin
            if (shift_ff) begin
               if (last_slot) begin
                  st_in = ST_TAIL;
               end
            end else if (ge) begin
               if (eq || !is_ins || full) begin
                  st_in = ST_RESP;
               end else if (last_slot) begin
                  st_in = ST_TAIL;
               end
            end else if (last_slot) begin
               st_in = ST_RESP;
            end
         end
         ST_TAIL: st_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // The row is scanned upward one slot a cycle. Once the insert point is
   // passed, each slot read is rewritten one place higher from a carry
   // register, so the search and the shift share a single pass.
   always_comb begin
      q_pop       = 1'b0;
      item_in     = item_ff;
      n_in        = n_ff;
      chk_in      = chk_ff;
      shift_in    = shift_ff;
      carry_in    = carry_ff;
      found_in    = found_ff;
      ovf_in      = ovf_ff;
      ins_in      = ins_ff;
      fill_rd_en  = 1'b0;
      fill_wr_en  = 1'b0;
      ent_rd_en   = 1'b0;
      ent_rd_slot = FW'(chk_ff + FW'(1));
      ent_wr_en   = 1'b0;
      ent_wr_slot = chk_ff;
      ent_wr_data = key;
      load_rsp    = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               item_in    = q_item;
               found_in   = 1'b0;
               ovf_in     = 1'b0;
               ins_in     = 1'b0;
               shift_in   = 1'b0;
               fill_rd_en = 1'b1;
            end
         end
         ST_FILL: begin
            n_in        = fill_cur;
            chk_in      = '0;
            ent_rd_en   = 1'b1;
            ent_rd_slot = '0;
            if (fill_cur == '0 && is_ins) begin
               ent_wr_en   = 1'b1;
               ent_wr_slot = '0;
               ins_in      = 1'b1;
            end
         end
         ST_SCAN: begin
            ent_rd_en = 1'b1;
            if (shift_ff) begin
               ent_wr_en   = 1'b1;
               ent_wr_data = carry_ff;
               carry_in    = ent_rdata;
               chk_in      = FW'(chk_ff + FW'(1));
            end else if (ge) begin
               if (eq) begin
                  found_in = 1'b1;
               end else if (is_ins) begin
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     ent_wr_en = 1'b1;
                     carry_in  = ent_rdata;
                     ins_in    = 1'b1;
                     shift_in  = 1'b1;
                     chk_in    = FW'(chk_ff + FW'(1));
                  end
               end
            end else if (last_slot) begin
               if (is_ins) begin
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     ent_wr_en   = 1'b1;
                     ent_wr_slot = FW'(chk_ff + FW'(1));
                     ins_in      = 1'b1;
                  end
               end
            end else begin
               chk_in = FW'(chk_ff + FW'(1));
            end
         end
         ST_TAIL: begin
            ent_wr_en   = 1'b1;
            ent_wr_slot = n_ff;
            ent_wr_data = carry_ff;
         end
         ST_RESP: begin
            load_rsp   = rsp_free;
            fill_wr_en = rsp_free && ins_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (fill_wr_en) begin
            valid_ff[row_idx] <= 1'b1;
            total_ff          <= total_new;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      n_ff     <= n_in;
      chk_ff   <= chk_in;
      shift_ff <= shift_in;
      carry_ff <= carry_in;
      found_ff <= found_in;
      ovf_ff   <= ovf_in;
      ins_ff   <= ins_in;
      if (load_rsp) begin
         rsp_ff.found         <= found_ff;
         rsp_ff.row_fill      <= fill_wide[FILL_OUT_W-1:0];
         rsp_ff.total_entries <= total_wide[TOTAL_OUT_W-1:0];
         rsp_ff.overflow      <= ovf_ff;
         rsp_ff.range_error   <= item_ff.rerr;
         rsp_ff.done_res      <= item_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hdl/sparse_row_sorted_set.sv -----
// Sorted column store per matrix row. Each insert or query word gives one
// response word carrying presence, the row's fill and the grand total. An
// accepted word goes through a two-word queue to a sequencer that reads the
// row's fill (up to MAX_PER_ROW entries), then walks the row's entry memory
// one slot per clock; a word on an empty row skips the walk and a word
// flagged out of range skips the fill read too. The sequencer takes a new
// word only once the last is answered. An insert shifts the tail of the row
// up during the same walk. Row fills are kept in a small memory behind one
// valid bit per row, so the store is empty right after reset with no
// clearing pass. The response sits in an output register, so the sequencer
// can start the next word while a response is stalled.
module sparse_row_sorted_set #(
   parameter int ROWS        = 256,
   parameter int MAX_PER_ROW = 32,
   parameter int COL_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [srss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [srss_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [srss_pkg::ROW_W-1:0]         req_row,
   input  logic [srss_pkg::COL_W-1:0]         req_col,
   input  logic                               req_batch_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [srss_pkg::FILL_OUT_W-1:0]    rsp_row_fill,
   output logic [srss_pkg::TOTAL_OUT_W-1:0]   rsp_total_entries,
   output logic                               rsp_overflow,
   output logic                               rsp_range_error,
   output logic                               rsp_done_res
);
   import srss_pkg::*;

   logic     q_full;
   logic     push;
   item_type push_item;
   logic     q_valid;
   logic     q_pop;
   item_type q_head;
   rsp_type  rsp;

   srss_front #(.ROWS(ROWS), .COL_BITS(COL_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_batch_last (req_batch_last),
      .q_full         (q_full),
      .push           (push),
      .push_item      (push_item)
   );

   srss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   srss_back #(.ROWS(ROWS), .MAX_PER_ROW(MAX_PER_ROW), .COL_BITS(COL_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign req_stall         = q_full;
   assign rsp_found         = rsp.found;
   assign rsp_row_fill      = rsp.row_fill;
   assign rsp_total_entries = rsp.total_entries;
   assign rsp_overflow      = rsp.overflow;
   assign rsp_range_error   = rsp.range_error;
   assign rsp_done_res      = rsp.done_res;

   // A flagged word leaves the row untouched and reports nothing about it.
   a_range_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |->
         !rsp_found && !rsp_overflow && (rsp_row_fill == '0))
      else $error("range error response carries row data");

   // A dropped insert only happens on a full row and never for a duplicate.
   a_overflow_full_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         !rsp_found && !rsp_range_error &&
         (rsp_row_fill == FILL_OUT_W'(MAX_PER_ROW)))
      else $error("overflow reported on a row that is not full");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import srss_pkg::*;

   localparam int ROWS        = 256;
   localparam int MAX_PER_ROW = 32;
   localparam int LIMIT       = 400000;
   localparam int DRAIN       = 50;
   localparam int HOLD_LONG   = 300;

   localparam logic KIND_QUERY = 1'b1;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [ROW_W-1:0]       req_row;
   logic [COL_W-1:0]       req_col;
   logic                   req_batch_last;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_found;
   logic [FILL_OUT_W-1:0]  rsp_row_fill;
   logic [TOTAL_OUT_W-1:0] rsp_total_entries;
   logic                   rsp_overflow;
   logic                   rsp_range_error;
   logic                   rsp_done_res;

   // Shadow copy of the sparsity pattern and of the two limit registers.
   logic [COL_W-1:0] stored_cols [ROWS][MAX_PER_ROW];
   int               stored_fill [ROWS];
   int               stored_total;
   int               lim_rows;
   int               lim_cols;

   rsp_type pending_rsp [$];
   int      errors;
   int      cycles;
   bit      steady;       // when set, neither side idles
   int      hold_cycles;  // one-shot long hold-off for the response side

   sparse_row_sorted_set i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   // Applies one word to the shadow pattern and returns the response it gives.
   function automatic rsp_type apply_word(input logic kind, input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col, input logic last);
      rsp_type r;
      int      n;
      int      pos;
      int      k;
      bit      hit;
      r = '0;
      r.done_res = last;
      if (int'(row) >= lim_rows || int'(col) >= lim_cols) begin
         r.range_error = 1'b1;
      end else begin
         n = stored_fill[row];
         pos = n;
         for (k = 0; k < n; k++) begin
            if (stored_cols[row][k] >= col) begin
               pos = k;
               break;
            end
         end
         hit = (pos < n) && (stored_cols[row][pos] == col);
         if (kind == KIND_INSERT && !hit) begin
            if (n >= MAX_PER_ROW) begin
               r.overflow = 1'b1;
            end else begin
               for (k = n; k > pos; k--) stored_cols[row][k] = stored_cols[row][k-1];
               stored_cols[row][pos] = col;
               n++;
               stored_fill[row] = n;
               stored_total++;
            end
         end
         r.found = hit;
         r.row_fill = n[FILL_OUT_W-1:0];
      end
      r.total_entries = stored_total[TOTAL_OUT_W-1:0];
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so a following word can go out without a gap.
   task automatic send_word(input logic kind, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_kind       = kind;
      req_row        = row;
      req_col        = col;
      req_batch_last = last;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_rsp = {pending_rsp, apply_word(kind, row, col, last)};
      @(negedge clock);
   endtask

   // Leaves the block idle: nothing offered and every response returned.
   task automatic settle();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      if (index == CSR_ROW_COUNT) lim_rows = int'(data[ROW_COUNT_W-1:0]);
      else lim_cols = int'(data[COL_COUNT_W-1:0]);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] rows,
                             input logic [CSR_DATA_W-1:0] cols);
      settle();
      csr_write(CSR_ROW_COUNT, rows);
      csr_write(CSR_COL_COUNT, cols);
   endtask

   task automatic run_batches(input int count, input int row_hi, input int col_hi);
      int          sent;
      int          len;
      logic [7:0]  row;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // Stray word with every field random, often breaking a batch.
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            row = 8'($urandom_range(0, row_hi));
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_word(($urandom_range(0, 3) == 0) ? KIND_QUERY : KIND_INSERT, row,
                         16'($urandom_range(0, col_hi)), i == len - 1);
            end
            sent += len;
         end
      end
   endtask

   task automatic test_basic_ops();
      send_word(KIND_INSERT, 8'd0, 16'd0, 1'b0);
      send_word(KIND_QUERY, 8'd0, 16'd0, 1'b0);
      send_word(KIND_INSERT, 8'd0, 16'd0, 1'b0);
      send_word(KIND_INSERT, 8'd0, 16'hFFFF, 1'b1);
      send_word(KIND_QUERY, 8'd0, 16'd1, 1'b0);
      send_word(KIND_INSERT, 8'd255, 16'hFFFF, 1'b0);
      send_word(KIND_INSERT, 8'd255, 16'd0, 1'b1);
      // Out-of-order columns so the later inserts land in front and between.
      send_word(KIND_INSERT, 8'd3, 16'd500, 1'b0);
      send_word(KIND_INSERT, 8'd3, 16'd100, 1'b0);
      send_word(KIND_INSERT, 8'd3, 16'd300, 1'b1);
      send_word(KIND_QUERY, 8'd3, 16'd300, 1'b0);
      send_word(KIND_QUERY, 8'd3, 16'd301, 1'b1);
      send_word(KIND_QUERY, 8'd255, 16'd1234, 1'b0);
   endtask

   task automatic test_range_limits();
      set_limits(17'd0, 17'd65536);
      send_word(KIND_INSERT, 8'd0, 16'd0, 1'b0);
      set_limits(17'd1, 17'd1);
      send_word(KIND_INSERT, 8'd0, 16'd0, 1'b0);
      send_word(KIND_INSERT, 8'd1, 16'd0, 1'b0);
      send_word(KIND_INSERT, 8'd0, 16'd1, 1'b1);
      set_limits(17'd1, 17'd0);
      send_word(KIND_QUERY, 8'd0, 16'd0, 1'b0);
      // Limits above the nominal range are used as they are.
      set_limits(17'h1FFFF, 17'h1FFFF);
      send_word(KIND_INSERT, 8'd255, 16'hFFFF, 1'b0);
      send_word(KIND_INSERT, 8'd128, 16'h8000, 1'b1);
      set_limits(17'd256, 17'd65536);
   endtask

   // Fills rows past capacity, then repeats a stored column into the full row.
   task automatic test_row_overflow();
      logic [7:0]  rows [4] = '{8'd10, 8'd11, 8'd200, 8'd254};
      logic [15:0] first_col;
      foreach (rows[r]) begin
         first_col = 16'($urandom);
         for (int i = 0; i < 34; i++) begin
            send_word(KIND_INSERT, rows[r], (i == 0) ? first_col : 16'($urandom), i % 8 == 7);
         end
         send_word(KIND_INSERT, rows[r], first_col, 1'b1);
         send_word(KIND_QUERY, rows[r], first_col, 1'b0);
      end
   endtask

   task automatic test_random_dense();
      run_batches(240, 15, 63);
      steady = 1'b1;
      run_batches(60, 15, 63);
      steady = 1'b0;
   endtask

   task automatic test_random_narrow();
      // Only the low nine bits count for the row limit: this sets 128 rows.
      set_limits(17'h10E80, 17'd4096);
      run_batches(250, 255, 5000);
   endtask

   task automatic test_random_wide();
      set_limits(17'd511, 17'h1FFFF);
      run_batches(180, 255, 65535);
      steady = 1'b1;
      run_batches(70, 255, 65535);
      steady = 1'b0;
   endtask

   // The response side holds off while words keep coming, filling the block.
   task automatic test_back_pressure();
      settle();
      steady = 1'b1;
      hold_cycles = HOLD_LONG;
      run_batches(30, 31, 255);
      settle();
      steady = 1'b0;
   endtask

   task automatic test_random_tiny();
      set_limits(17'd1, 17'd1);
      run_batches(40, 1, 1);
   endtask

   // Response side: random hold-off per word, plus the one-shot long hold.
   initial begin : rsp_side
      int wait_cycles;
      forever begin
         wait_cycles = draw_gap() + hold_cycles;
         hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with none outstanding");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("found", 16'(want.found), 16'(rsp_found));
            check_field("row_fill", 16'(want.row_fill), 16'(rsp_row_fill));
            check_field("total_entries", 16'(want.total_entries),
                        16'(rsp_total_entries));
            check_field("overflow", 16'(want.overflow), 16'(rsp_overflow));
            check_field("range_error", 16'(want.range_error), 16'(rsp_range_error));
            check_field("done_res", 16'(want.done_res), 16'(rsp_done_res));
         end
      end
   end

   initial begin
      errors         = 0;
      cycles         = 0;
      steady         = 1'b0;
      hold_cycles    = 0;
      stored_total   = 0;
      lim_rows       = int'(ROW_COUNT_RESET);
      lim_cols       = int'(COL_COUNT_RESET);
      foreach (stored_fill[r]) stored_fill[r] = 0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_ROW_COUNT;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_kind       = KIND_INSERT;
      req_row        = '0;
      req_col        = '0;
      req_batch_last = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_range_limits();
      test_row_overflow();
      test_random_dense();
      test_random_narrow();
      test_random_wide();
      test_back_pressure();
      test_random_tiny();

      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
